FILE: rtl/lmsp_pkg.sv
// Shared constants, types and helpers for the LED marquee script player.
package lmsp_pkg;

  localparam int FRAME_WIDTH  = 8;
  localparam int FRAME_HEIGHT = 8;
  localparam int SCRIPT_DEPTH = 1024;
  localparam int FRAME_BITS   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int SA_W         = $clog2(SCRIPT_DEPTH);
  localparam int PTR_W        = 11;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // APB byte address of max_elapsed_ms
  localparam logic [1:0] ADDR_MAX_ELAPSED = 2'd0;

  localparam logic [6:0] CH_LBRACK = 7'h5B;
  localparam logic [6:0] CH_RBRACK = 7'h5D;
  localparam logic [6:0] CH_D      = 7'h64;
  localparam logic [6:0] CH_T      = 7'h74;
  localparam logic [6:0] CH_L      = 7'h6C;
  localparam logic [6:0] CH_S      = 7'h73;
  localparam logic [6:0] CH_M      = 7'h6D;
  localparam logic [6:0] CH_R      = 7'h72;
  localparam logic [6:0] CH_U      = 7'h75;
  localparam logic [6:0] CH_ZERO   = 7'h30;

  localparam logic [30:0] DELAY_RESET = 31'd1000;
  localparam logic [15:0] MAX_EL_RESET = 16'd1000;

  localparam logic [PTR_W-1:0] DEPTH_W = PTR_W'(SCRIPT_DEPTH);

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_APPEND, OP_LOAD, OP_CLEAR, OP_COUNT, OP_READ,
    OP_ADV, OP_SHOW, OP_DIGIT, OP_SET_DELAY, OP_SET_MODE, OP_SET_DIR,
    OP_LOOP, OP_GREAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic       cd_run;     // countdown nonpositive: step
    logic       empty;      // script_end == 0
    logic       at_end;     // ptr >= end
    logic [6:0] ch;         // char read at ptr (0 past end)
  } stat_t;

  function automatic logic [FRAME_BITS-1:0] mask_frame(input logic [63:0] v);
    return v[FRAME_BITS-1:0];
  endfunction

endpackage

FILE: rtl/lmsp_ram.sv
// Generic single-port RAM with registered read.
module lmsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/lmsp_datapath.sv
// Datapath: script and glyph stores, frame, timer and mode registers.
module lmsp_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  lmsp_pkg::cmd_t             cmd,
  input  logic [31:0]                now_ms,
  input  logic [6:0]                 char_code,
  input  logic [63:0]                glyph_bits,
  input  logic [15:0]                max_elapsed_ms,
  output lmsp_pkg::stat_t            stat,
  output logic [63:0]                frame_bits,
  output logic [10:0]                script_position,
  output logic                       scrolling,
  output logic                       stalled
);
  localparam int FW = lmsp_pkg::FRAME_WIDTH;
  localparam int FH = lmsp_pkg::FRAME_HEIGHT;
  localparam int FB = lmsp_pkg::FRAME_BITS;
  localparam int SW = lmsp_pkg::SA_W;
  localparam int PW = lmsp_pkg::PTR_W;

  logic [PW-1:0] script_end, script_ptr;
  logic [127:0]  glyph_present;
  logic [FB-1:0] frame;
  logic [31:0]   countdown, last_time;
  logic [30:0]   step_delay, dur;
  logic [6:0]    show_mode, scroll_dir;
  logic          scroll_idle;
  logic [3:0]    scroll_pos;

  lmsp_pkg::op_t op;
  assign op = cmd.op;

  // script memory
  logic          s_we;
  logic [SW-1:0] s_addr;
  logic [6:0]    s_rdata;
  assign s_we   = (op == lmsp_pkg::OP_APPEND) && (script_end < lmsp_pkg::DEPTH_W);
  assign s_addr = s_we ? script_end[SW-1:0] : script_ptr[SW-1:0];
  lmsp_ram #(.WIDTH(7), .DEPTH(lmsp_pkg::SCRIPT_DEPTH)) u_script (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(char_code), .rdata(s_rdata));

  // char register: read at ptr, zero past end
  logic [6:0] ch;
  logic       ch_ok;
  always_ff @(posedge clk) begin
    if (op == lmsp_pkg::OP_READ) ch_ok <= (script_ptr < script_end);
  end
  assign ch = ch_ok ? s_rdata : 7'd0;

  // glyph memory, read address from current char
  logic        g_we;
  logic [6:0]  g_addr;
  logic [63:0] g_rdata;
  assign g_we   = (op == lmsp_pkg::OP_LOAD);
  assign g_addr = g_we ? char_code : ch;
  lmsp_ram #(.WIDTH(64), .DEPTH(128)) u_glyph (
    .clk(clk), .we(g_we), .addr(g_addr), .wdata(glyph_bits), .rdata(g_rdata));

  logic mode_known, horiz;
  assign mode_known = (show_mode == lmsp_pkg::CH_S) ||
    ((show_mode == lmsp_pkg::CH_M) && (scroll_dir == lmsp_pkg::CH_L ||
      scroll_dir == lmsp_pkg::CH_R || scroll_dir == lmsp_pkg::CH_U ||
      scroll_dir == lmsp_pkg::CH_D));
  assign horiz = (scroll_dir == lmsp_pkg::CH_L) || (scroll_dir == lmsp_pkg::CH_R);

  logic [PW-1:0] ptr_inc;
  assign ptr_inc = (script_ptr < script_end) ? script_ptr + 1'b1 : script_ptr;

  // elapsed time clamp
  logic [31:0] el, el_c;
  assign el   = now_ms - last_time;
  assign el_c = (el > {16'd0, max_elapsed_ms}) ? {16'd0, max_elapsed_ms} : el;

  // scroll step frame
  logic [FB-1:0] scr_frame;
  logic [3:0]    span;
  assign span = horiz ? 4'(FW) : 4'(FH);
  always_comb begin
    scr_frame = '0;
    for (int h = 0; h < FH; h++) begin
      for (int w = 0; w < FW; w++) begin
        if (scroll_dir == lmsp_pkg::CH_L) begin
          if (w == FW-1) scr_frame[h*FW+w] = g_rdata[h*FW + int'(scroll_pos)];
          else           scr_frame[h*FW+w] = frame[h*FW+w+1];
        end else if (scroll_dir == lmsp_pkg::CH_R) begin
          if (w == 0) scr_frame[h*FW+w] = g_rdata[h*FW + FW-1-int'(scroll_pos)];
          else        scr_frame[h*FW+w] = frame[h*FW+w-1];
        end else if (scroll_dir == lmsp_pkg::CH_U) begin
          if (h == FH-1) scr_frame[h*FW+w] = g_rdata[int'(scroll_pos)*FW + w];
          else           scr_frame[h*FW+w] = frame[(h+1)*FW+w];
        end else begin
          if (h == 0) scr_frame[h*FW+w] = g_rdata[(FH-1-int'(scroll_pos))*FW + w];
          else        scr_frame[h*FW+w] = frame[(h-1)*FW+w];
        end
      end
    end
  end

  logic [30:0] delay_div;
  assign delay_div = horiz ? 31'(step_delay / FW) : 31'(step_delay / FH);

  logic [34:0] dmul;
  assign dmul = {dur, 3'b0} + {2'b0, dur, 1'b0} + 35'(ch) - 35'(lmsp_pkg::CH_ZERO);

  always_ff @(posedge clk) begin
    if (rst) begin
      script_end <= '0; script_ptr <= '0; glyph_present <= '0; frame <= '0;
      countdown <= '0; last_time <= '0; step_delay <= lmsp_pkg::DELAY_RESET;
      show_mode <= lmsp_pkg::CH_S; scroll_dir <= '0; scroll_idle <= 1'b1;
      scroll_pos <= '0; dur <= '0;
    end else begin
      unique case (op)
        lmsp_pkg::OP_APPEND: if (s_we) script_end <= script_end + 1'b1;
        lmsp_pkg::OP_LOAD:   glyph_present[char_code] <= 1'b1;
        lmsp_pkg::OP_CLEAR: begin
          script_ptr <= '0; script_end <= '0; frame <= '0;
          scroll_idle <= 1'b1; scroll_pos <= '0;
        end
        lmsp_pkg::OP_COUNT: begin
          countdown <= countdown - el_c;
          last_time <= now_ms;
        end
        lmsp_pkg::OP_ADV: script_ptr <= ptr_inc;
        lmsp_pkg::OP_SHOW: begin
          if (glyph_present[ch] && mode_known) begin
            if (show_mode == lmsp_pkg::CH_S) begin
              frame <= g_rdata[FB-1:0];
              countdown <= {1'b0, step_delay};
              script_ptr <= ptr_inc;
              scroll_idle <= 1'b1; scroll_pos <= '0;
            end else if (scroll_idle || scroll_pos < span) begin
              frame <= scr_frame;
              countdown <= {1'b0, delay_div};
              scroll_idle <= 1'b0;
              scroll_pos <= scroll_idle ? 4'd1 : scroll_pos + 1'b1;
            end else begin
              script_ptr <= ptr_inc;
              scroll_idle <= 1'b1; scroll_pos <= '0;
            end
          end
        end
        lmsp_pkg::OP_DIGIT:     dur <= dmul[30:0];
        // accumulator starts from zero for the next [dN]
        lmsp_pkg::OP_SET_DELAY: begin
          step_delay <= dur;
          dur <= '0;
        end
        lmsp_pkg::OP_SET_MODE:  show_mode <= ch;
        lmsp_pkg::OP_SET_DIR:   scroll_dir <= ch;
        lmsp_pkg::OP_LOOP:      script_ptr <= '0;
        default: ;
      endcase
    end
  end

  assign stat.cd_run = (countdown == 32'd0) || countdown[31];
  assign stat.empty  = (script_end == '0);
  assign stat.at_end = (script_ptr >= script_end);
  assign stat.ch     = ch;

  assign frame_bits      = 64'(frame);
  assign script_position = script_ptr;
  assign scrolling       = !scroll_idle;
  // s_rdata holds the char at the final pointer while the result is shown
  assign stalled = !stat.empty && !stat.at_end && (s_rdata != lmsp_pkg::CH_LBRACK) &&
                   (!glyph_present[s_rdata] || !mode_known);
endmodule

FILE: rtl/lmsp_ctrl.sv
// Controller: sequences one item through datapath operations.
module lmsp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      req_type,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  lmsp_pkg::stat_t stat,
  output lmsp_pkg::cmd_t  cmd
);
  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001, S_RD0  = 15'b000000000000010,
    S_CH0   = 15'b000000000000100, S_GRD  = 15'b000000000001000,
    S_SHOW  = 15'b000000000010000, S_CMD  = 15'b000000000100000,
    S_DRD   = 15'b000000001000000, S_DCH  = 15'b000000010000000,
    S_TRD   = 15'b000000100000000, S_TCH  = 15'b000001000000000,
    S_MRD   = 15'b000010000000000, S_MCH  = 15'b000100000000000,
    S_FIN   = 15'b001000000000000, S_RES  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] fin_cnt, fin_cnt_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next   = state;
    fin_cnt_next = fin_cnt;
    cmd.op       = lmsp_pkg::OP_NONE;
    unique case (state)
      S_IDLE: if (in_valid) begin
        state_next = S_RES;
        unique case (req_type)
          lmsp_pkg::REQ_APPEND: cmd.op = lmsp_pkg::OP_APPEND;
          lmsp_pkg::REQ_LOAD:   cmd.op = lmsp_pkg::OP_LOAD;
          lmsp_pkg::REQ_CLEAR:  cmd.op = lmsp_pkg::OP_CLEAR;
          default: begin
            if (!stat.cd_run) cmd.op = lmsp_pkg::OP_COUNT;
            else if (stat.empty) cmd.op = lmsp_pkg::OP_NONE;
            else if (stat.at_end) cmd.op = lmsp_pkg::OP_CLEAR;
            else begin
              cmd.op = lmsp_pkg::OP_READ;
              state_next = S_CH0;
            end
          end
        endcase
      end
      S_CH0: begin
        if (stat.ch != lmsp_pkg::CH_LBRACK) state_next = S_GRD;
        else begin
          cmd.op = lmsp_pkg::OP_ADV;
          state_next = S_RD0;
        end
      end
      S_GRD:  state_next = S_SHOW;   // glyph read latency
      S_SHOW: begin
        cmd.op = lmsp_pkg::OP_SHOW;
        state_next = S_RES;
      end
      S_RD0: begin
        cmd.op = lmsp_pkg::OP_READ;
        state_next = S_CMD;
      end
      S_CMD: begin
        if (stat.ch == lmsp_pkg::CH_D) begin
          cmd.op = lmsp_pkg::OP_ADV;
          state_next = S_DRD;
        end else if (stat.ch == lmsp_pkg::CH_T) begin
          cmd.op = lmsp_pkg::OP_ADV;
          state_next = S_TRD;
        end else if (stat.ch == lmsp_pkg::CH_L) begin
          cmd.op = lmsp_pkg::OP_LOOP;
          state_next = S_RES;
        end else state_next = S_RES;
      end
      S_DRD: begin
        if (stat.at_end) begin
          cmd.op = lmsp_pkg::OP_SET_DELAY;
          state_next = S_RES;
        end else begin
          cmd.op = lmsp_pkg::OP_READ;
          state_next = S_DCH;
        end
      end
      S_DCH: begin
        if (stat.ch == lmsp_pkg::CH_RBRACK) begin
          cmd.op = lmsp_pkg::OP_SET_DELAY;
          fin_cnt_next = 2'd1;
          state_next = S_FIN;
        end else begin
          cmd.op = lmsp_pkg::OP_DIGIT;
          state_next = S_FIN;
          fin_cnt_next = 2'd0;
        end
      end
      S_TRD: begin
        cmd.op = lmsp_pkg::OP_READ;
        state_next = S_TCH;
      end
      S_TCH: begin
        cmd.op = lmsp_pkg::OP_SET_MODE;
        if (stat.ch == lmsp_pkg::CH_M) state_next = S_MRD;
        else begin
          fin_cnt_next = 2'd2;
          state_next = S_FIN;
        end
      end
      S_MRD: begin
        cmd.op = lmsp_pkg::OP_ADV;
        state_next = S_MCH;
        fin_cnt_next = 2'd3;
      end
      S_MCH: begin
        if (fin_cnt == 2'd3) begin
          cmd.op = lmsp_pkg::OP_READ;
          fin_cnt_next = 2'd0;
        end else begin
          cmd.op = lmsp_pkg::OP_SET_DIR;
          fin_cnt_next = 2'd2;
          state_next = S_FIN;
        end
      end
      // fin_cnt 0: advance inside digit walk, 1: final advance, 2: two advances
      S_FIN: begin
        cmd.op = lmsp_pkg::OP_ADV;
        if (fin_cnt == 2'd0) state_next = S_DRD;
        else if (fin_cnt == 2'd2) fin_cnt_next = 2'd1;
        else state_next = S_RES;
      end
      // script store reads the char at the final pointer for the stalled flag
      S_RES: state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fin_cnt <= '0;
    end else begin
      state   <= state_next;
      fin_cnt <= fin_cnt_next;
    end
  end
endmodule

FILE: rtl/led_marquee_script_player.sv
// Top level of the LED marquee script player.
// Usage: items enter on in_valid/in_stall with req_type, now_ms, char_code,
// glyph_bits. Each item yields one result on out_valid/out_stall carrying
// frame_bits, script_position, scrolling and stalled after the item is done.
// The controller reads one script character per memory access, and in its
// S_RES state before each result re-reads the character at the final pointer.
// One item is in flight at a time; in_stall stays high until its result is
// taken, and the next item can be accepted in the following cycle.
// Reset clears the script, glyph-present bits, frame and timers; the stores
// themselves are not cleared. While out_stall is high the result holds and
// no new item is accepted. max_elapsed_ms sits at APB address 0.
module led_marquee_script_player (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] now_ms,
  input  logic [6:0]  char_code,
  input  logic [63:0] glyph_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] frame_bits,
  output logic [10:0] script_position,
  output logic        scrolling,
  output logic        stalled,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] max_elapsed_ms;
  lmsp_pkg::stat_t stat;
  lmsp_pkg::cmd_t  cmd;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) max_elapsed_ms <= lmsp_pkg::MAX_EL_RESET;
    else if (psel && penable && pwrite && paddr == lmsp_pkg::ADDR_MAX_ELAPSED)
      max_elapsed_ms <= pwdata[15:0];
  end
  assign prdata = (paddr == lmsp_pkg::ADDR_MAX_ELAPSED) ? {16'd0, max_elapsed_ms} : 32'd0;

  lmsp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .req_type(req_type),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd));

  lmsp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .now_ms(now_ms), .char_code(char_code),
    .glyph_bits(glyph_bits), .max_elapsed_ms(max_elapsed_ms), .stat(stat),
    .frame_bits(frame_bits), .script_position(script_position),
    .scrolling(scrolling), .stalled(stalled));

  a_excl: assert property (@(posedge clk) disable iff (rst) !(out_valid && !in_stall))
    else $error("result shown while input open");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(script_position))
    else $error("result changed under stall");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    script_position <= 11'(lmsp_pkg::SCRIPT_DEPTH))
    else $error("script pointer out of range");
endmodule

FILE: test/led_marquee_script_player_chk.sv
`timescale 1ns / 100ps
// Checker: watches the item channels, predicts player results and compares them.
module led_marquee_script_player_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] now_ms,
  input  logic [6:0]  char_code,
  input  logic [63:0] glyph_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] frame_bits,
  input  logic [10:0] script_position,
  input  logic        scrolling,
  input  logic        stalled,
  input  logic [15:0] clamp_ms,
  output int          fail_count,
  output int          pending,
  output int          seen_results,
  output int          seen_steps,
  output int          seen_scrolls,
  output int          seen_stalls
);

  typedef struct packed {
    logic [63:0] frame;
    logic [10:0] pos;
    logic        scroll;
    logic        stall;
  } view_t;

  view_t       view_q[$];
  logic [6:0]  scr[lmsp_pkg::SCRIPT_DEPTH];
  logic [63:0] gly[128];
  logic        have[128];
  int unsigned s_end, s_ptr, cdown, dly, spos, t_last;
  logic [6:0]  mode, dir;
  logic        idle;
  logic [63:0] frm;

  assign pending = view_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] %s: got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [6:0] rd(input int unsigned i);
    return (i < s_end) ? scr[i] : 7'd0;
  endfunction

  function automatic void adv();
    if (s_ptr < s_end) s_ptr++;
  endfunction

  function automatic logic mode_ok();
    if (mode == lmsp_pkg::CH_S) return 1'b1;
    if (mode != lmsp_pkg::CH_M) return 1'b0;
    return dir == lmsp_pkg::CH_L || dir == lmsp_pkg::CH_R ||
           dir == lmsp_pkg::CH_U || dir == lmsp_pkg::CH_D;
  endfunction

  function automatic void wipe();
    s_ptr = 0; s_end = 0; frm = '0; idle = 1'b1; spos = 0;
  endfunction

  function automatic logic px(input logic [63:0] v, input int r, input int c);
    return v[r*lmsp_pkg::FRAME_WIDTH+c];
  endfunction

  function automatic void scroll_in(input logic [63:0] g);
    logic [63:0] nx;
    int dx, dy, sr, sc, span, edge_len;
    int p;
    int fw, fh;
    fw = lmsp_pkg::FRAME_WIDTH;
    fh = lmsp_pkg::FRAME_HEIGHT;
    span = (dir == lmsp_pkg::CH_L || dir == lmsp_pkg::CH_R) ? fw : fh;
    edge_len = (dir == lmsp_pkg::CH_L || dir == lmsp_pkg::CH_R) ? fh : fw;
    p = spos;
    dx = (dir == lmsp_pkg::CH_L) ? -1 : (dir == lmsp_pkg::CH_R) ? 1 : 0;
    dy = (dir == lmsp_pkg::CH_U) ? -1 : (dir == lmsp_pkg::CH_D) ? 1 : 0;
    nx = '0;
    for (int h = 0; h < fh; h++)
      for (int w = 0; w < fw; w++) begin
        sr = h - dy; sc = w - dx;
        if (sr >= 0 && sr < fh && sc >= 0 && sc < fw && px(frm, sr, sc))
          nx[h*fw+w] = 1'b1;
      end
    for (int k = 0; k < edge_len; k++) begin
      // fill the entering column or row from the glyph
      if (dir == lmsp_pkg::CH_L) nx[k*fw+fw-1] = px(g, k, p);
      else if (dir == lmsp_pkg::CH_R) nx[k*fw] = px(g, k, fw-1-p);
      else if (dir == lmsp_pkg::CH_U) nx[(fh-1)*fw+k] = px(g, p, k);
      else nx[k] = px(g, fh-1-p, k);
    end
    frm = nx;
    cdown = dly / span;
    spos++;
  endfunction

  function automatic void show(input logic [6:0] c);
    int span;
    if (!have[c] || !mode_ok()) return;
    if (mode == lmsp_pkg::CH_S) begin
      frm = gly[c]; cdown = dly; adv(); idle = 1'b1; spos = 0;
      return;
    end
    span = (dir == lmsp_pkg::CH_L || dir == lmsp_pkg::CH_R) ?
           lmsp_pkg::FRAME_WIDTH : lmsp_pkg::FRAME_HEIGHT;
    if (idle) begin
      idle = 1'b0; spos = 0;
    end
    if (spos < span) scroll_in(gly[c]);
    else begin
      adv(); idle = 1'b1; spos = 0;
    end
  endfunction

  function automatic void script_step();
    logic [6:0] c;
    int unsigned d;
    if (s_end == 0) return;
    if (s_ptr >= s_end) begin
      wipe();
      return;
    end
    c = rd(s_ptr);
    if (c != lmsp_pkg::CH_LBRACK) begin
      show(c);
      return;
    end
    adv();
    c = rd(s_ptr);
    if (c == lmsp_pkg::CH_D) begin
      d = 0;
      forever begin
        adv();
        if (s_ptr >= s_end) break;
        c = rd(s_ptr);
        if (c == lmsp_pkg::CH_RBRACK) break;
        d = (d * 10 + c - lmsp_pkg::CH_ZERO) & 32'h7fff_ffff;
      end
      dly = d;
      adv();
    end else if (c == lmsp_pkg::CH_T) begin
      adv();
      mode = rd(s_ptr);
      if (mode == lmsp_pkg::CH_M) begin
        adv();
        dir = rd(s_ptr);
      end
      adv(); adv();
    end else if (c == lmsp_pkg::CH_L) s_ptr = 0;
  endfunction

  function automatic view_t apply_item(input logic [1:0] rq, input logic [31:0] now,
                                       input logic [6:0] cc, input logic [63:0] gb);
    view_t v;
    int unsigned el;
    logic [6:0] c;
    case (rq)
      lmsp_pkg::REQ_TICK: begin
        if (cdown == 0 || cdown[31]) script_step();
        else begin
          el = now - t_last;
          if (el > clamp_ms) el = clamp_ms;
          cdown = cdown - el;
          t_last = now;
        end
      end
      lmsp_pkg::REQ_APPEND: begin
        if (s_end < lmsp_pkg::SCRIPT_DEPTH) begin
          scr[s_end] = cc; s_end++;
        end
      end
      lmsp_pkg::REQ_LOAD: begin
        gly[cc] = gb; have[cc] = 1'b1;
      end
      default: wipe();
    endcase
    v.stall = 1'b0;
    if (s_end > 0 && s_ptr < s_end) begin
      c = rd(s_ptr);
      if (c != lmsp_pkg::CH_LBRACK && (!have[c] || !mode_ok())) v.stall = 1'b1;
    end
    v.frame = frm; v.pos = s_ptr[10:0]; v.scroll = !idle;
    return v;
  endfunction

  always @(posedge clk) begin
    view_t w, g;
    if (rst) begin
      view_q.delete();
      s_end = 0; s_ptr = 0; frm = '0; cdown = 0; dly = lmsp_pkg::DELAY_RESET;
      mode = lmsp_pkg::CH_S; dir = 0; idle = 1'b1; spos = 0; t_last = 0;
      foreach (have[i]) have[i] = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (req_type == lmsp_pkg::REQ_TICK && (cdown == 0 || cdown[31]) && s_end > 0)
          seen_steps++;
        view_q.push_back(apply_item(req_type, now_ms, char_code, glyph_bits));
      end
      if (out_valid && !out_stall) begin
        seen_results++;
        g = '{frame_bits, script_position, scrolling, stalled};
        if (scrolling) seen_scrolls++;
        if (stalled) seen_stalls++;
        if (view_q.size() == 0) report("result with nothing expected", g.pos, 0);
        else begin
          w = view_q.pop_front();
          if (g.frame !== w.frame) report("frame_bits", g.frame, w.frame);
          if (g.pos !== w.pos) report("script_position", g.pos, w.pos);
          if (g.scroll !== w.scroll) report("scrolling", g.scroll, w.scroll);
          if (g.stall !== w.stall) report("stalled", g.stall, w.stall);
        end
      end
    end
  end

  initial begin
    fail_count = 0; seen_results = 0; seen_steps = 0; seen_scrolls = 0; seen_stalls = 0;
  end

endmodule

FILE: test/led_marquee_script_player_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives script, glyph and tick items and the clamp register.
module led_marquee_script_player_tb;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [1:0]  req_type;
  logic [31:0] now_ms;
  logic [6:0]  char_code;
  logic [63:0] glyph_bits;
  logic [63:0] frame_bits;
  logic [10:0] script_position;
  logic        scrolling, stalled;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic [15:0] clamp_ms;
  int          fail_count, pending, seen_results, seen_steps, seen_scrolls, seen_stalls;
  int          cycles;
  int          idle_pct_in, idle_pct_out, hold_left;
  logic [31:0] clock_ms;

  localparam int LIMIT = 2_000_000;

  led_marquee_script_player dut (.*);

  led_marquee_script_player_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver side: random stalls plus one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else out_stall <= ($urandom_range(99) < idle_pct_out);
    end
  end

  // in_stall seen at a falling edge holds through the next rising edge
  task automatic send(input logic [1:0] rq, input logic [31:0] now, input logic [6:0] cc,
                      input logic [63:0] gb);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct_in) @(negedge clk);
    in_valid <= 1'b1; req_type <= rq; now_ms <= now; char_code <= cc; glyph_bits <= gb;
    while (in_stall) @(negedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic tick(input int unsigned step_ms);
    clock_ms += step_ms;
    send(lmsp_pkg::REQ_TICK, clock_ms, 7'($urandom), {$urandom, $urandom});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send(lmsp_pkg::REQ_APPEND, $urandom, 7'(s[i]), {$urandom, $urandom});
  endtask

  task automatic set_clamp(input logic [15:0] v);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= lmsp_pkg::ADDR_MAX_ELAPSED; pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    clamp_ms = v;
  endtask

  function automatic logic [6:0] pick_char();
    case ($urandom_range(9))
      0, 1: return lmsp_pkg::CH_LBRACK;
      2: return lmsp_pkg::CH_RBRACK;
      3: return lmsp_pkg::CH_D;
      4: return lmsp_pkg::CH_T;
      5: return 7'($urandom_range(7'h30, 7'h39));
      6: return 7'($urandom);
      default: return 7'($urandom_range(7'h41, 7'h44));
    endcase
  endfunction

  initial begin
    string modes[4];
    modes = '{"[tml]", "[tmr]", "[tmu]", "[tmd]"};
    rst = 1'b1; in_valid = 1'b0; req_type = lmsp_pkg::REQ_TICK; now_ms = '0;
    char_code = '0; glyph_bits = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; clamp_ms = lmsp_pkg::MAX_EL_RESET; idle_pct_in = 35;
    idle_pct_out = 35; hold_left = 0; clock_ms = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: glyph extremes, delay, mode and loop commands, stalls, end of script, clear
    send(lmsp_pkg::REQ_LOAD, 0, 7'h41, 64'hffff_ffff_ffff_ffff);
    send(lmsp_pkg::REQ_LOAD, 0, 7'h42, 64'h0);
    send(lmsp_pkg::REQ_LOAD, 0, 7'h7f, 64'h8142_2418_1824_4281);
    tick(1);
    add_text("[d5]A[tmr]B[tx]Z[tq]A[l]");
    repeat (30) tick(3);
    send(lmsp_pkg::REQ_CLEAR, 0, 0, 0);
    add_text("[d123");
    repeat (3) tick(1);
    send(lmsp_pkg::REQ_APPEND, 0, 7'h7f, 0);
    tick(32'hffff_fff0);
    repeat (4) tick(1);
    set_clamp(16'hffff);
    set_clamp(16'h0);
    repeat (4) tick(9);

    // random phases: well-formed scripts mostly, some noise
    for (int ph = 0; ph < 6; ph++) begin
      set_clamp(ph == 2 ? 16'h0 : ph == 3 ? 16'hffff : 16'($urandom_range(1, 40)));
      if (ph == 1) begin
        idle_pct_in = 0; idle_pct_out = 0;
      end else begin
        idle_pct_in = 35; idle_pct_out = 35;
      end
      if (ph == 4) hold_left = 300;
      send(lmsp_pkg::REQ_CLEAR, 0, 0, 0);
      for (int g = 0; g < 4; g++)
        send(lmsp_pkg::REQ_LOAD, 0, 7'(7'h41 + g), {$urandom, $urandom});
      add_text($sformatf("[d%0d]", $urandom_range(0, 30)));
      for (int k = 0; k < 12; k++) begin
        case ($urandom_range(5))
          0: add_text(modes[$urandom_range(3)]);
          1: add_text("[ts]");
          2: add_text($sformatf("[d%0d]", $urandom_range(0, 40)));
          3: send(lmsp_pkg::REQ_APPEND, 0, pick_char(), 0);
          default: send(lmsp_pkg::REQ_APPEND, 0, 7'($urandom_range(7'h41, 7'h45)), 0);
        endcase
      end
      if ($urandom_range(1)) add_text("[l]");
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(19) == 0)
          send(lmsp_pkg::REQ_LOAD, 0, 7'($urandom), {$urandom, $urandom});
        else if ($urandom_range(29) == 0) send(lmsp_pkg::REQ_APPEND, 0, pick_char(), 0);
        else tick($urandom_range(0, 25));
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("covered %0d results, %0d script steps, %0d while scrolling, %0d stalled",
             seen_results, seen_steps, seen_scrolls, seen_stalls);
    $display("clamp at zero, full scale and small values; bursts and a long hold-off");
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: led_marquee_script_player.f
rtl/lmsp_pkg.sv
rtl/lmsp_ram.sv
rtl/lmsp_datapath.sv
rtl/lmsp_ctrl.sv
rtl/led_marquee_script_player.sv
test/led_marquee_script_player_chk.sv
test/led_marquee_script_player_tb.sv
